>>> rtl/aalu_pkg.sv
`timescale 1ns / 1ps

package aalu_pkg;

    // operation codes carried in the kind field
    typedef enum logic [4:0] {
        K_NEG  = 5'd0,
        K_COM  = 5'd1,
        K_LSR  = 5'd2,
        K_ROR  = 5'd3,
        K_ASR  = 5'd4,
        K_ASL  = 5'd5,
        K_ROL  = 5'd6,
        K_DEC  = 5'd7,
        K_INC  = 5'd8,
        K_TST  = 5'd9,
        K_CLR  = 5'd10,
        K_SUB  = 5'd11,
        K_CMP  = 5'd12,
        K_SBC  = 5'd13,
        K_AND  = 5'd14,
        K_BIT  = 5'd15,
        K_LD   = 5'd16,
        K_ST   = 5'd17,
        K_EOR  = 5'd18,
        K_ADC  = 5'd19,
        K_OR   = 5'd20,
        K_ADD  = 5'd21,
        K_SUBD = 5'd22,
        K_CMPX = 5'd23,
        K_LDX  = 5'd24,
        K_STX  = 5'd25,
        K_ADDD = 5'd26,
        K_LDD  = 5'd27,
        K_STD  = 5'd28,
        K_LDU  = 5'd29,
        K_STU  = 5'd30
    } kind_t;

    // condition code bit positions
    localparam int unsigned CC_H = 4;
    localparam int unsigned CC_N = 3;
    localparam int unsigned CC_Z = 2;
    localparam int unsigned CC_V = 1;
    localparam int unsigned CC_C = 0;

    localparam logic [7:0] SIGN8 = 8'h80;
    localparam logic [7:0] MAXPOS8 = 8'h7F;

    // programmer-visible register file
    typedef struct packed {
        logic [7:0]  acc_a;
        logic [7:0]  acc_b;
        logic [15:0] index_x;
        logic [15:0] user_stack;
        logic [4:0]  cc;
    } aalu_state_t;

endpackage

>>> rtl/aalu_exec.sv
`timescale 1ns / 1ps

module aalu_exec
    import aalu_pkg::*;
(
    input  aalu_state_t st,
    input  logic [4:0]  kind,
    input  logic        target_b,
    input  logic [15:0] operand,
    output aalu_state_t st_next,
    output logic [15:0] value,
    output logic        is_store
);

    logic [7:0]  reg8;
    logic [7:0]  m;
    logic        cin;
    logic [15:0] d;
    logic [15:0] src16;
    logic [8:0]  neg9;
    logic [8:0]  sub9;
    logic [8:0]  add9;
    logic [16:0] sub17;
    logic [16:0] add17;
    logic [7:0]  r8;
    logic [15:0] r16;
    logic        wr8;
    logic [4:0]  cc;

    assign reg8  = target_b ? st.acc_b : st.acc_a;
    assign m     = operand[7:0];
    assign cin   = st.cc[CC_C];
    assign d     = {st.acc_a, st.acc_b};
    assign src16 = (kind == K_CMPX) ? st.index_x : d;

    assign neg9  = 9'd0 - {1'b0, reg8};
    assign sub9  = {1'b0, reg8} - {1'b0, m} - {8'd0, (kind == K_SBC) ? cin : 1'b0};
    assign add9  = {1'b0, reg8} + {1'b0, m} + {8'd0, (kind == K_ADC) ? cin : 1'b0};
    assign sub17 = {1'b0, src16} - {1'b0, operand};
    assign add17 = {1'b0, d} + {1'b0, operand};

    always_comb
    begin
        st_next  = st;
        cc       = st.cc;
        value    = 16'd0;
        is_store = 1'b0;
        wr8      = 1'b0;
        r8       = reg8;
        r16      = d;
        case (kind_t'(kind))
            K_NEG:
            begin
                r8       = neg9[7:0];
                cc[CC_V] = reg8[7] & neg9[7];
                cc[CC_C] = neg9[8];
                wr8      = 1'b1;
            end
            K_COM:
            begin
                r8       = ~reg8;
                cc[CC_V] = 1'b0;
                cc[CC_C] = 1'b1;
                wr8      = 1'b1;
            end
            K_LSR, K_ROR, K_ASR:
            begin
                case (kind_t'(kind))
                    K_LSR:   r8 = {1'b0, reg8[7:1]};
                    K_ROR:   r8 = {cin, reg8[7:1]};
                    default: r8 = {reg8[7], reg8[7:1]};
                endcase
                cc[CC_C] = reg8[0];
                wr8      = 1'b1;
            end
            K_ASL, K_ROL:
            begin
                r8       = {reg8[6:0], (kind == K_ROL) ? cin : 1'b0};
                cc[CC_V] = reg8[7] ^ reg8[6];
                cc[CC_C] = reg8[7];
                wr8      = 1'b1;
            end
            K_DEC:
            begin
                r8       = reg8 - 8'd1;
                cc[CC_V] = (reg8 == SIGN8);
                wr8      = 1'b1;
            end
            K_INC:
            begin
                r8       = reg8 + 8'd1;
                cc[CC_V] = (reg8 == MAXPOS8);
                wr8      = 1'b1;
            end
            K_TST, K_ST:
            begin
                cc[CC_V] = 1'b0;
                value    = {8'd0, reg8};
                is_store = (kind == K_ST);
            end
            K_CLR:
            begin
                r8       = 8'd0;
                cc[CC_V] = 1'b0;
                cc[CC_C] = 1'b0;
                wr8      = 1'b1;
            end
            K_SUB, K_SBC, K_CMP:
            begin
                r8       = sub9[7:0];
                cc[CC_V] = ((reg8[7] ^ m[7]) & (reg8[7] ^ sub9[7]));
                cc[CC_C] = sub9[8];
                wr8      = (kind != K_CMP);
                value    = {8'd0, reg8};
            end
            K_AND, K_BIT:
            begin
                r8       = reg8 & m;
                cc[CC_V] = 1'b0;
                wr8      = (kind == K_AND);
                value    = {8'd0, reg8};
            end
            K_LD:
            begin
                r8       = m;
                cc[CC_V] = 1'b0;
                wr8      = 1'b1;
            end
            K_EOR, K_OR:
            begin
                r8       = (kind == K_EOR) ? (reg8 ^ m) : (reg8 | m);
                cc[CC_V] = 1'b0;
                wr8      = 1'b1;
            end
            K_ADD, K_ADC:
            begin
                r8       = add9[7:0];
                cc[CC_H] = reg8[4] ^ m[4] ^ add9[4];
                cc[CC_V] = ~(reg8[7] ^ m[7]) & (reg8[7] ^ add9[7]);
                cc[CC_C] = add9[8];
                wr8      = 1'b1;
            end
            K_SUBD, K_CMPX:
            begin
                r16      = sub17[15:0];
                cc[CC_V] = (src16[15] ^ operand[15]) & (src16[15] ^ sub17[15]);
                cc[CC_C] = sub17[16];
                if (kind == K_SUBD)
                begin
                    st_next.acc_a = r16[15:8];
                    st_next.acc_b = r16[7:0];
                    value         = r16;
                end
                else
                begin
                    value = st.index_x;
                end
            end
            K_ADDD:
            begin
                r16           = add17[15:0];
                cc[CC_V]      = ~(d[15] ^ operand[15]) & (d[15] ^ add17[15]);
                cc[CC_C]      = add17[16];
                st_next.acc_a = r16[15:8];
                st_next.acc_b = r16[7:0];
                value         = r16;
            end
            K_LDD, K_LDX, K_LDU:
            begin
                r16      = operand;
                cc[CC_V] = 1'b0;
                value    = operand;
                case (kind_t'(kind))
                    K_LDD:
                    begin
                        st_next.acc_a = operand[15:8];
                        st_next.acc_b = operand[7:0];
                    end
                    K_LDX:   st_next.index_x    = operand;
                    default: st_next.user_stack = operand;
                endcase
            end
            K_STD, K_STX, K_STU:
            begin
                case (kind_t'(kind))
                    K_STD:   r16 = d;
                    K_STX:   r16 = st.index_x;
                    default: r16 = st.user_stack;
                endcase
                cc[CC_V] = 1'b0;
                value    = r16;
                is_store = 1'b1;
            end
            default:
            begin
                value = 16'd0;
            end
        endcase

        // n and z come from the 8-bit or the 16-bit result
        if (kind <= K_ADD)
        begin
            cc[CC_N] = r8[7];
            cc[CC_Z] = (r8 == 8'd0);
        end
        else if (kind <= K_STU)
        begin
            cc[CC_N] = r16[15];
            cc[CC_Z] = (r16 == 16'd0);
        end

        if (wr8)
        begin
            if (target_b)
                st_next.acc_b = r8;
            else
                st_next.acc_a = r8;
            value = {8'd0, r8};
        end
        st_next.cc = cc;
    end

endmodule

>>> rtl/accumulator_alu_with_condition_codes.sv
`timescale 1ns / 1ps

// channel  | dir | fields (lowest bit first)                         | transfer when
// ---------+-----+---------------------------------------------------+----------------------
// s_axis   | in  | tdata: operand[15:0]; tuser: kind[4:0], target_b  | tvalid & tready
// m_axis   | out | tdata: value[15:0], h, n, z, v, c, 3'b0;          | tvalid & tready
//          |     | tuser: is_store                                   |
//
// an accepted item sits in the input register while the alu works on it, and the
// register file and the result register load from the alu when the result slot is
// free or being emptied; one item per cycle sustained while m_axis is not stalled
// the combinational alu path against the register file sets the rate: the next item
// sees the registers left by the one before it with no bypass needed
// rst_n clears the registers, the flags and both valid bits
// a stall on m_axis holds the result; the input register still takes one more item

module accumulator_alu_with_condition_codes
    import aalu_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,  // operand[15:0]
    input  logic [5:0]  s_axis_tuser,  // kind[4:0], target_b[5]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,  // value[15:0], h, n, z, v, c, zero fill
    output logic [0:0]  m_axis_tuser   // is_store
);

    // input register
    logic        in_valid_reg;
    logic        in_valid_next;
    logic [4:0]  in_kind_reg;
    logic        in_target_b_reg;
    logic [15:0] in_operand_reg;

    // register file
    aalu_state_t state_reg;
    aalu_state_t state_next;

    // result register
    logic        out_valid_reg;
    logic        out_valid_next;
    logic [15:0] out_value_reg;
    logic        out_store_reg;
    logic [4:0]  out_cc_reg;

    logic [15:0] alu_value;
    logic        alu_store;
    logic        s_xfer;
    logic        adv;

    // the held item moves on when the result slot is free or being emptied
    assign adv            = in_valid_reg & (~out_valid_reg | m_axis_tready);
    assign s_axis_tready  = ~in_valid_reg | adv;
    assign s_xfer         = s_axis_tvalid & s_axis_tready;
    assign in_valid_next  = s_xfer | (in_valid_reg & ~adv);
    assign out_valid_next = adv | (out_valid_reg & ~m_axis_tready);

    aalu_exec u_exec (
        .st       (state_reg),
        .kind     (in_kind_reg),
        .target_b (in_target_b_reg),
        .operand  (in_operand_reg),
        .st_next  (state_next),
        .value    (alu_value),
        .is_store (alu_store)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (adv)
                state_reg <= state_next;
        end
    end

    // payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (s_xfer)
        begin
            in_kind_reg     <= s_axis_tuser[4:0];
            in_target_b_reg <= s_axis_tuser[5];
            in_operand_reg  <= s_axis_tdata;
        end
        if (adv)
        begin
            out_value_reg <= alu_value;
            out_store_reg <= alu_store;
            out_cc_reg    <= state_next.cc;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {3'b000, out_cc_reg[CC_C], out_cc_reg[CC_V], out_cc_reg[CC_Z],
                            out_cc_reg[CC_N], out_cc_reg[CC_H], out_value_reg};
    assign m_axis_tuser  = out_store_reg;

    // registers only change when an item goes through the alu
    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(state_reg))
        else $error("register file changed without an item");

    // a held item with an empty result slot must move on
    a_no_bubble: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !out_valid_reg) |-> adv)
        else $error("input register stalled with free result slot");

    // a new result appears only after an item advanced
    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(adv))
        else $error("result valid without an item");

    // store operations leave the data registers untouched
    a_store_keeps: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && alu_store) |=> ($stable(state_reg.acc_a) && $stable(state_reg.acc_b)
            && $stable(state_reg.index_x) && $stable(state_reg.user_stack)))
        else $error("store changed a register");

    // flags in the result match the flag register after the update
    a_cc_match: assert property (@(posedge clk) disable iff (!rst_n)
        adv |=> (out_cc_reg == state_reg.cc))
        else $error("result flags differ from flag register");

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps

module tb;

    import aalu_pkg::*;

    // kind value outside the operation set
    localparam logic [4:0] KIND_UNUSED = 5'd31;
    localparam int unsigned IDLE_LIMIT = 2000;
    localparam int unsigned RANDOM_OPS = 950;
    localparam int unsigned LONG_HOLD = 150;
    localparam int unsigned DRAIN_CYCLES = 10;

    typedef struct packed {
        logic [15:0] value;
        logic        store;
        logic        fh;
        logic        fn;
        logic        fz;
        logic        fv;
        logic        fc;
    } alu_result_t;

    class alu_scoreboard;
        logic [7:0]  reg_a;
        logic [7:0]  reg_b;
        logic [15:0] reg_x;
        logic [15:0] reg_u;
        logic [4:0]  ccr;
        alu_result_t awaited[$];
        int unsigned errors;
        int unsigned noted;
        int unsigned checked;

        function new();
            reg_a = '0;
            reg_b = '0;
            reg_x = '0;
            reg_u = '0;
            ccr = '0;
            errors = 0;
            noted = 0;
            checked = 0;
        endfunction

        function void set_nz8(logic [7:0] r);
            ccr[CC_N] = r[7];
            ccr[CC_Z] = (r == 8'h00);
        endfunction

        function void set_nz16(logic [15:0] r);
            ccr[CC_N] = r[15];
            ccr[CC_Z] = (r == 16'h0000);
        endfunction

        function void logic_flags8(logic [7:0] r);
            set_nz8(r);
            ccr[CC_V] = 1'b0;
        endfunction

        function void logic_flags16(logic [15:0] r);
            set_nz16(r);
            ccr[CC_V] = 1'b0;
        endfunction

        function logic [7:0] sub8(logic [7:0] a, logic [7:0] b, logic borrow);
            logic [8:0] w;
            w = {1'b0, a} - {1'b0, b} - {8'h00, borrow};
            set_nz8(w[7:0]);
            ccr[CC_V] = (a[7] ^ b[7]) & (a[7] ^ w[7]);
            ccr[CC_C] = w[8];
            return w[7:0];
        endfunction

        function logic [7:0] add8(logic [7:0] a, logic [7:0] b, logic carry);
            logic [8:0] w;
            w = {1'b0, a} + {1'b0, b} + {8'h00, carry};
            ccr[CC_H] = a[4] ^ b[4] ^ w[4];
            set_nz8(w[7:0]);
            ccr[CC_V] = ~(a[7] ^ b[7]) & (a[7] ^ w[7]);
            ccr[CC_C] = w[8];
            return w[7:0];
        endfunction

        function logic [15:0] sub16(logic [15:0] a, logic [15:0] b);
            logic [16:0] w;
            w = {1'b0, a} - {1'b0, b};
            set_nz16(w[15:0]);
            ccr[CC_V] = (a[15] ^ b[15]) & (a[15] ^ w[15]);
            ccr[CC_C] = w[16];
            return w[15:0];
        endfunction

        function logic [15:0] add16(logic [15:0] a, logic [15:0] b);
            logic [16:0] w;
            w = {1'b0, a} + {1'b0, b};
            set_nz16(w[15:0]);
            ccr[CC_V] = ~(a[15] ^ b[15]) & (a[15] ^ w[15]);
            ccr[CC_C] = w[16];
            return w[15:0];
        endfunction

        // runs one operation on the shadow registers and queues its outcome
        function void note_input(logic [4:0] kind, logic sel_b, logic [15:0] opnd);
            logic [7:0]  acc;
            logic [7:0]  m;
            logic [7:0]  r8;
            logic [15:0] d;
            logic [15:0] value;
            logic        cin;
            logic        store;
            logic        wr8;
            alu_result_t outcome;
            acc = sel_b ? reg_b : reg_a;
            m = opnd[7:0];
            cin = ccr[CC_C];
            d = {reg_a, reg_b};
            r8 = acc;
            value = '0;
            store = 1'b0;
            wr8 = 1'b0;
            case (kind)
                K_NEG: begin r8 = sub8(8'h00, acc, 1'b0); wr8 = 1'b1; end
                K_COM:
                begin
                    r8 = ~acc;
                    logic_flags8(r8);
                    ccr[CC_C] = 1'b1;
                    wr8 = 1'b1;
                end
                K_LSR, K_ROR, K_ASR:
                begin
                    if (kind == K_LSR)
                        r8 = {1'b0, acc[7:1]};
                    else if (kind == K_ROR)
                        r8 = {cin, acc[7:1]};
                    else
                        r8 = {acc[7], acc[7:1]};
                    set_nz8(r8);
                    ccr[CC_C] = acc[0];
                    wr8 = 1'b1;
                end
                K_ASL, K_ROL:
                begin
                    r8 = {acc[6:0], (kind == K_ROL) ? cin : 1'b0};
                    set_nz8(r8);
                    ccr[CC_V] = acc[7] ^ acc[6];
                    ccr[CC_C] = acc[7];
                    wr8 = 1'b1;
                end
                K_DEC:
                begin
                    r8 = acc - 8'd1;
                    set_nz8(r8);
                    ccr[CC_V] = (acc == SIGN8);
                    wr8 = 1'b1;
                end
                K_INC:
                begin
                    r8 = acc + 8'd1;
                    set_nz8(r8);
                    ccr[CC_V] = (acc == MAXPOS8);
                    wr8 = 1'b1;
                end
                K_TST: begin logic_flags8(acc); value = {8'h00, acc}; end
                K_CLR:
                begin
                    r8 = 8'h00;
                    logic_flags8(r8);
                    ccr[CC_C] = 1'b0;
                    wr8 = 1'b1;
                end
                K_SUB: begin r8 = sub8(acc, m, 1'b0); wr8 = 1'b1; end
                K_CMP: begin void'(sub8(acc, m, 1'b0)); value = {8'h00, acc}; end
                K_SBC: begin r8 = sub8(acc, m, cin); wr8 = 1'b1; end
                K_AND: begin r8 = acc & m; logic_flags8(r8); wr8 = 1'b1; end
                K_BIT: begin logic_flags8(acc & m); value = {8'h00, acc}; end
                K_LD: begin r8 = m; logic_flags8(r8); wr8 = 1'b1; end
                K_ST:
                begin
                    logic_flags8(acc);
                    value = {8'h00, acc};
                    store = 1'b1;
                end
                K_EOR: begin r8 = acc ^ m; logic_flags8(r8); wr8 = 1'b1; end
                K_ADC: begin r8 = add8(acc, m, cin); wr8 = 1'b1; end
                K_OR: begin r8 = acc | m; logic_flags8(r8); wr8 = 1'b1; end
                K_ADD: begin r8 = add8(acc, m, 1'b0); wr8 = 1'b1; end
                K_SUBD, K_ADDD, K_LDD:
                begin
                    if (kind == K_SUBD)
                        d = sub16(d, opnd);
                    else if (kind == K_ADDD)
                        d = add16(d, opnd);
                    else
                    begin
                        d = opnd;
                        logic_flags16(d);
                    end
                    reg_a = d[15:8];
                    reg_b = d[7:0];
                    value = d;
                end
                K_CMPX: begin void'(sub16(reg_x, opnd)); value = reg_x; end
                K_LDX: begin reg_x = opnd; logic_flags16(opnd); value = opnd; end
                K_STX: begin logic_flags16(reg_x); value = reg_x; store = 1'b1; end
                K_STD: begin logic_flags16(d); value = d; store = 1'b1; end
                K_LDU: begin reg_u = opnd; logic_flags16(opnd); value = opnd; end
                K_STU: begin logic_flags16(reg_u); value = reg_u; store = 1'b1; end
                default: ;
            endcase
            if (wr8)
            begin
                if (sel_b)
                    reg_b = r8;
                else
                    reg_a = r8;
                value = {8'h00, r8};
            end
            outcome.value = value;
            outcome.store = store;
            outcome.fh = ccr[CC_H];
            outcome.fn = ccr[CC_N];
            outcome.fz = ccr[CC_Z];
            outcome.fv = ccr[CC_V];
            outcome.fc = ccr[CC_C];
            awaited.push_back(outcome);
            noted++;
        endfunction

        function void compare(string what, logic [15:0] want, logic [15:0] got);
            if (got !== want)
            begin
                errors++;
                $display("%0t: %s mismatch, expected %h, got %h", $time, what, want, got);
            end
        endfunction

        function void check_result(logic [23:0] data, logic [0:0] user);
            alu_result_t want;
            if (awaited.size() == 0)
            begin
                errors++;
                $display("%0t: result with nothing expected, value %h", $time, data[15:0]);
                return;
            end
            want = awaited.pop_front();
            checked++;
            compare("value", want.value, data[15:0]);
            compare("is_store", {15'd0, want.store}, {15'd0, user[0]});
            compare("flag_h", {15'd0, want.fh}, {15'd0, data[16]});
            compare("flag_n", {15'd0, want.fn}, {15'd0, data[17]});
            compare("flag_z", {15'd0, want.fz}, {15'd0, data[18]});
            compare("flag_v", {15'd0, want.fv}, {15'd0, data[19]});
            compare("flag_c", {15'd0, want.fc}, {15'd0, data[20]});
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata = '0;
    logic [5:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;
    logic [0:0]  m_axis_tuser;

    // pacing controls for the sender and the receiver
    bit hold_req = 1'b0;
    bit eager = 1'b0;
    bit burst = 1'b0;

    alu_scoreboard sb;

    always
    begin
        #1 clk = 1'b0;
        #1 clk = 1'b1;
    end

    accumulator_alu_with_condition_codes i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // mostly short gaps, now and then a long one
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // operands biased towards sign, carry and zero boundaries
    function automatic logic [15:0] pick_operand();
        case ($urandom_range(0, 9))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return 16'h8000;
            3: return 16'h7FFF;
            4: return {8'($urandom), 8'h80};
            5: return {8'($urandom), 8'h7F};
            6: return {8'($urandom), 8'h0F};
            default: return 16'($urandom);
        endcase
    endfunction

    // one input transfer, after an optional idle gap
    task automatic send_item(input logic [4:0] kind, input logic sel_b,
                             input logic [15:0] opnd);
        int unsigned gap;
        gap = (eager || burst) ? 0 : pick_gap();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= opnd;
        s_axis_tuser <= {sel_b, kind};
        do
            @(posedge clk);
        while (!s_axis_tready);
        sb.note_input(kind, sel_b, opnd);
    endtask

    task automatic send_random();
        logic [4:0] kind;
        if ($urandom_range(0, 63) == 0)
            kind = KIND_UNUSED;
        else
            kind = 5'($urandom_range(0, 30));
        send_item(kind, 1'($urandom), pick_operand());
    endtask

    // stop offering and let every outstanding result come back
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (sb.awaited.size() != 0)
            @(posedge clk);
    endtask

    // result side: check each transfer, then choose tready for the next cycle
    initial
    begin
        int unsigned stall_left;
        int unsigned hold_left;
        logic        ready_next;
        stall_left = 0;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (m_axis_tvalid && m_axis_tready)
                sb.check_result(m_axis_tdata, m_axis_tuser);
            if (hold_req)
            begin
                hold_req = 1'b0;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                // long back-pressure so the block fills up and stalls its input
                hold_left--;
                ready_next = 1'b0;
            end
            else if (burst)
                ready_next = 1'b1;
            else if (stall_left > 0)
            begin
                stall_left--;
                ready_next = 1'b0;
            end
            else
            begin
                stall_left = pick_gap();
                ready_next = (stall_left == 0);
                if (stall_left > 0)
                    stall_left--;
            end
            m_axis_tready <= ready_next;
        end
    end

    // watchdog on cycles with no transfer on either side
    initial
    begin
        int unsigned idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("tb: errors");
        $finish;
    end

    initial
    begin
        sb = new();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: every operation at least once, boundary operands, flag corner cases
        send_item(K_LD,   1'b0, 16'h007F);
        send_item(K_INC,  1'b0, 16'h0000);  // 7f -> 80 overflows
        send_item(K_DEC,  1'b0, 16'hFFFF);  // 80 -> 7f overflows
        send_item(K_LD,   1'b1, 16'hFF80);
        send_item(K_NEG,  1'b1, 16'h0000);  // negating 80 overflows
        send_item(K_COM,  1'b1, 16'h0000);
        send_item(K_LSR,  1'b1, 16'h0000);
        send_item(K_ROR,  1'b1, 16'h0000);
        send_item(K_ASR,  1'b0, 16'h0000);
        send_item(K_ASL,  1'b0, 16'h0000);
        send_item(K_ROL,  1'b1, 16'h0000);
        send_item(K_TST,  1'b0, 16'hFFFF);  // register left unchanged
        send_item(K_CLR,  1'b1, 16'h0000);
        send_item(K_SUB,  1'b0, 16'h00FF);
        send_item(K_CMP,  1'b0, 16'h0001);
        send_item(K_SBC,  1'b1, 16'h0000);  // borrow in from the carry flag
        send_item(K_AND,  1'b0, 16'h00F0);
        send_item(K_BIT,  1'b0, 16'h000F);
        send_item(K_ST,   1'b1, 16'h0000);
        send_item(K_EOR,  1'b0, 16'h00FF);
        send_item(K_ADC,  1'b0, 16'h0001);
        send_item(K_OR,   1'b1, 16'h0080);
        send_item(K_ADD,  1'b0, 16'h0008);  // no carry out of bit 3 here, half carry stays clear
        send_item(K_SUBD, 1'b0, 16'hFFFF);
        send_item(K_LDX,  1'b0, 16'h8000);
        send_item(K_CMPX, 1'b0, 16'h7FFF);
        send_item(K_STX,  1'b0, 16'h0000);
        send_item(K_ADDD, 1'b0, 16'h8000);
        send_item(K_LDD,  1'b1, 16'h0000);
        send_item(K_STD,  1'b0, 16'hFFFF);
        send_item(K_LDU,  1'b0, 16'hFFFF);
        send_item(K_STU,  1'b1, 16'h0000);
        send_item(KIND_UNUSED, 1'b1, 16'hFFFF);
        drain();

        for (int unsigned i = 0; i < RANDOM_OPS; i++)
        begin
            if (i == 300)
            begin
                hold_req = 1'b1;
                eager = 1'b1;
            end
            if (i == 360)
                eager = 1'b0;
            if (i == 600)
                drain();
            burst = (i >= 700) && (i < 800);
            send_random();
        end
        burst = 1'b0;
        drain();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("summary: %0d operations sent, %0d results checked, %0d mismatches",
                 sb.noted, sb.checked, sb.errors);
        $display("summary: all kinds on both accumulators, long output stall and idle drain");
        if (sb.errors == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule

>>> filelist.f
rtl/aalu_pkg.sv
rtl/aalu_exec.sv
rtl/accumulator_alu_with_condition_codes.sv
tb/tb.sv
